>>> src/fstc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fstc_pkg - fan speed timer controller shared definitions
// Level, key and command codes, the classified operation word and the
// seven-segment helpers.
// ----------------------------------------------------------------------------
package fstc_pkg;

  // command field codes
  localparam logic [1:0] CMD_KEY    = 2'd0;
  localparam logic [1:0] CMD_TICK   = 2'd1;
  localparam logic [1:0] CMD_SERIAL = 2'd2;

  // drive levels, -3 .. +3
  localparam logic [7:0] LVL_M3   = 8'h00;
  localparam logic [7:0] LVL_M2   = 8'h20;
  localparam logic [7:0] LVL_M1   = 8'h40;
  localparam logic [7:0] LVL_IDLE = 8'h80;
  localparam logic [7:0] LVL_P1   = 8'hC0;
  localparam logic [7:0] LVL_P2   = 8'hE0;
  localparam logic [7:0] LVL_P3   = 8'hFF;

  // remote key codes
  localparam logic [7:0] KEY_POWER  = 8'h45;
  localparam logic [7:0] KEY_MODE   = 8'h46;
  localparam logic [7:0] KEY_DOWN_A = 8'h15;
  localparam logic [7:0] KEY_DOWN_B = 8'h40;
  localparam logic [7:0] KEY_UP_A   = 8'h09;
  localparam logic [7:0] KEY_UP_B   = 8'h43;
  localparam logic [7:0] KEY_CLEAR  = 8'h16;
  localparam logic [7:0] KEY_ADD10  = 8'h0c;
  localparam logic [7:0] KEY_ADD20  = 8'h18;
  localparam logic [7:0] KEY_ADD30  = 8'h5e;
  localparam logic [7:0] KEY_ADD40  = 8'h08;
  localparam logic [7:0] KEY_ADD50  = 8'h1c;
  localparam logic [7:0] KEY_ADD60  = 8'h5a;
  localparam logic [7:0] KEY_ADD70  = 8'h42;
  localparam logic [7:0] KEY_ADD80  = 8'h52;
  localparam logic [7:0] KEY_SET90  = 8'h4a;

  // time limits
  localparam logic [7:0] SER_MIN_MAX = 8'd99;
  localparam logic [7:0] SER_SEC_MAX = 8'd59;
  localparam logic [6:0] MIN_FULL    = 7'd90;
  localparam logic [5:0] SEC_WRAP    = 6'd59;
  localparam logic [7:0] TPS_RESET   = 8'd20;

  // segment codes
  localparam logic [6:0] SEG_MINUS = 7'h40;
  localparam logic [6:0] SEG_E     = 7'h79;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_POWER,
    OP_MODE,
    OP_DOWN,
    OP_UP,
    OP_CLEAR,
    OP_ADD,
    OP_SET90,
    OP_TICK,
    OP_SERIAL
  } op_code_t;

  // one classified word, front to back
  typedef struct packed {
    op_code_t    op;
    logic [6:0]  add_min;     // minutes added by a digit key
    logic [6:0]  add_limit;   // add only while minutes <= this
    logic [7:0]  level;       // serial level
    logic [6:0]  minutes;     // serial minutes (valid if min_ok)
    logic [5:0]  seconds;     // serial seconds (valid if sec_ok)
    logic        min_ok;
    logic        sec_ok;
    logic        set_timing;
  } fstc_op_t;

  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'h3f;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5b;
      4'd3:    s = 7'h4f;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6d;
      4'd6:    s = 7'h7d;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7f;
      4'd9:    s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // split 0..99 into {tens, ones}
  function automatic logic [7:0] split_dec(input logic [6:0] v);
    logic [3:0] tens;
    logic [3:0] ones;
    tens = 4'd0;
    for (int i = 1; i <= 9; i++) begin
      if (v >= 7'(10 * i)) tens = 4'(i);
    end
    ones = 4'(v - 7'(tens) * 7'd10);
    return {tens, ones};
  endfunction

endpackage
`default_nettype wire

>>> src/fstc_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fstc_ifs - fan speed timer controller channels
// Input event channel, result channel and tick reload write channel.
// ----------------------------------------------------------------------------
interface fstc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] key_code;
  logic [7:0] key_inverse;
  logic [7:0] serial_level;
  logic [7:0] serial_minutes;
  logic [7:0] serial_seconds;

  modport source (output valid, cmd, key_code, key_inverse, serial_level,
                  serial_minutes, serial_seconds, input ready);
  modport sink   (input valid, cmd, key_code, key_inverse, serial_level,
                  serial_minutes, serial_seconds, output ready);
endinterface

interface fstc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] drive_level;
  logic [6:0] minutes_left;
  logic [5:0] seconds_left;
  logic       fan_running;
  logic       timer_active;
  logic [6:0] seg_level_sign;
  logic [6:0] seg_level_digit;
  logic [6:0] seg_min_tens;
  logic [6:0] seg_min_ones;
  logic [6:0] seg_sec_tens;
  logic [6:0] seg_sec_ones;

  modport source (output valid, drive_level, minutes_left, seconds_left, fan_running,
                  timer_active, seg_level_sign, seg_level_digit, seg_min_tens,
                  seg_min_ones, seg_sec_tens, seg_sec_ones, input ready);
  modport sink   (input valid, drive_level, minutes_left, seconds_left, fan_running,
                  timer_active, seg_level_sign, seg_level_digit, seg_min_tens,
                  seg_min_ones, seg_sec_tens, seg_sec_ones, output ready);
endinterface

interface fstc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> src/fan_speed_timer_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fan_speed_timer_controller - fan drive level and countdown controller
// Takes remote key, timer tick and serial set events and returns one
// status word with level, time, flags and display codes per event.
// ----------------------------------------------------------------------------
// Every accepted input word (remote key, base tick or serial set) yields
// exactly one result word, in order. The block takes one input word per
// clock and returns one result per clock for as long as the result side
// keeps ready high; a result word passes through the queue slot, written
// when its input is taken, and then the executor's output register before
// it is offered. The queue is QUEUE_DEPTH words deep, so the input side
// stays ready for that many words while the result side is stalled. The
// tick reload (cfg) is to be written only while the block is idle; the
// block itself does not enforce this. It takes effect at the next
// prescaler rollover and resets to 20.
// ----------------------------------------------------------------------------
module fan_speed_timer_controller #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  fstc_in_if.sink     in_bus,
  fstc_out_if.source  out_bus,
  fstc_cfg_if.sink    cfg_bus
);
  import fstc_pkg::*;

  // ticks per countdown second, reload value of the prescaler
  logic [7:0] tps_r;

  logic     push_valid, push_ready;
  fstc_op_t push_op;
  logic     pop_valid, pop_ready;
  fstc_op_t pop_op;

  // config writes are always taken
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_bus.valid) begin
      tps_r <= cfg_bus.data;
    end
  end

  // front: key check and decode into an operation word
  fstc_front u_front (
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  // queue decouples the classifier from the executor
  fstc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // back: state update, display encode, output register
  fstc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick_reload (tps_r),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_op      (pop_op),
    .out_bus     (out_bus)
  );

endmodule
`default_nettype wire

>>> src/fstc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fstc_front - event classifier
// Checks remote keys, decodes them into operations and prequalifies
// serial set commands before they enter the queue.
// ----------------------------------------------------------------------------
module fstc_front (
  fstc_in_if.sink          in_bus,
  output logic             push_valid,
  input  logic             push_ready,
  output fstc_pkg::fstc_op_t push_op
);
  import fstc_pkg::*;

  logic       key_ok;
  logic [3:0] tens_n;

  assign key_ok       = (in_bus.key_inverse == ~in_bus.key_code);
  assign in_bus.ready = push_ready;
  assign push_valid   = in_bus.valid;

  always_comb begin
    push_op            = '0;
    push_op.op         = OP_NONE;
    tens_n             = 4'd0;
    push_op.level      = in_bus.serial_level;
    push_op.minutes    = in_bus.serial_minutes[6:0];
    push_op.seconds    = in_bus.serial_seconds[5:0];
    push_op.min_ok     = (in_bus.serial_minutes <= SER_MIN_MAX);
    push_op.sec_ok     = (in_bus.serial_seconds <= SER_SEC_MAX);
    push_op.set_timing = (in_bus.serial_minutes != 8'd0) || (in_bus.serial_seconds != 8'd0);

    unique case (in_bus.cmd)
      CMD_KEY: begin
        if (key_ok) begin
          unique case (in_bus.key_code)
            KEY_POWER:            push_op.op = OP_POWER;
            KEY_MODE:             push_op.op = OP_MODE;
            KEY_DOWN_A, KEY_DOWN_B: push_op.op = OP_DOWN;
            KEY_UP_A, KEY_UP_B:   push_op.op = OP_UP;
            KEY_CLEAR:            push_op.op = OP_CLEAR;
            KEY_SET90:            push_op.op = OP_SET90;
            KEY_ADD10: begin push_op.op = OP_ADD; tens_n = 4'd1; end
            KEY_ADD20: begin push_op.op = OP_ADD; tens_n = 4'd2; end
            KEY_ADD30: begin push_op.op = OP_ADD; tens_n = 4'd3; end
            KEY_ADD40: begin push_op.op = OP_ADD; tens_n = 4'd4; end
            KEY_ADD50: begin push_op.op = OP_ADD; tens_n = 4'd5; end
            KEY_ADD60: begin push_op.op = OP_ADD; tens_n = 4'd6; end
            KEY_ADD70: begin push_op.op = OP_ADD; tens_n = 4'd7; end
            KEY_ADD80: begin push_op.op = OP_ADD; tens_n = 4'd8; end
            default:              push_op.op = OP_NONE;
          endcase
        end
      end
      CMD_TICK:   push_op.op = OP_TICK;
      CMD_SERIAL: push_op.op = OP_SERIAL;
      default:    push_op.op = OP_NONE;
    endcase

    push_op.add_min   = 7'(tens_n) * 7'd10;
    push_op.add_limit = MIN_FULL - 7'(tens_n) * 7'd10;
  end

endmodule
`default_nettype wire

>>> src/fstc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fstc_queue - operation queue
// Small register FIFO between classifier and executor.
// ----------------------------------------------------------------------------
module fstc_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fstc_pkg::fstc_op_t push_op,
  output logic               pop_valid,
  input  logic               pop_ready,
  output fstc_pkg::fstc_op_t pop_op
);
  import fstc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fstc_op_t          slot_r [DEPTH];
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     rptr_r, rptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

endmodule
`default_nettype wire

>>> src/fstc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fstc_back - operation executor
// Holds fan and timer state, applies one queued operation per cycle while
// the output is drained and registers the result word with its display codes.
// ----------------------------------------------------------------------------
module fstc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         tick_reload,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  fstc_pkg::fstc_op_t pop_op,
  fstc_out_if.source         out_bus
);
  import fstc_pkg::*;

  typedef struct packed {
    logic [7:0] level;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic       running;
    logic       timing;
    logic [6:0] seg_sign;
    logic [6:0] seg_digit;
    logic [6:0] seg_mt;
    logic [6:0] seg_mo;
    logic [6:0] seg_st;
    logic [6:0] seg_so;
  } res_t;

  logic       running_r, running_nxt;
  logic       timing_r, timing_nxt;
  logic [7:0] level_r, level_nxt;
  logic [6:0] minutes_r, minutes_nxt;
  logic [5:0] seconds_r, seconds_nxt;
  logic [7:0] presc_r, presc_nxt;
  logic       out_valid_r;
  res_t       res_r, res_nxt;
  logic [7:0] presc_dec;
  logic [7:0] min_dec, sec_dec;
  logic       take;

  // output stage refills when empty or being drained
  assign pop_ready = !out_valid_r || out_bus.ready;
  assign take      = pop_valid && pop_ready;
  assign presc_dec = presc_r - 8'd1;

  function automatic logic [7:0] mirror(input logic [7:0] l);
    logic [7:0] r;
    case (l)
      LVL_M3:  r = LVL_P3;
      LVL_M2:  r = LVL_P2;
      LVL_M1:  r = LVL_P1;
      LVL_P1:  r = LVL_M1;
      LVL_P2:  r = LVL_M2;
      LVL_P3:  r = LVL_M3;
      default: r = l;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] step_down(input logic [7:0] l);
    logic [7:0] r;
    case (l)
      LVL_M3:  r = LVL_M2;
      LVL_M2:  r = LVL_M1;
      LVL_M1:  r = LVL_IDLE;
      LVL_P1:  r = LVL_IDLE;
      LVL_P2:  r = LVL_P1;
      LVL_P3:  r = LVL_P2;
      default: r = l;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] step_up(input logic [7:0] l);
    logic [7:0] r;
    case (l)
      LVL_M2:   r = LVL_M3;
      LVL_M1:   r = LVL_M2;
      LVL_IDLE: r = LVL_P1;
      LVL_P1:   r = LVL_P2;
      LVL_P2:   r = LVL_P3;
      default:  r = l;
    endcase
    return r;
  endfunction

  always_comb begin
    logic [7:0] lvl_tmp;
    running_nxt = running_r;
    timing_nxt  = timing_r;
    level_nxt   = level_r;
    minutes_nxt = minutes_r;
    seconds_nxt = seconds_r;
    presc_nxt   = presc_r;
    lvl_tmp     = level_r;

    if (take) begin
      unique case (pop_op.op)
        OP_POWER: begin
          if (!running_r) begin
            running_nxt = 1'b1;
            level_nxt   = LVL_P1;
          end else begin
            running_nxt = 1'b0;
            level_nxt   = LVL_IDLE;
            minutes_nxt = '0;
            seconds_nxt = '0;
          end
          timing_nxt = 1'b0;
        end
        OP_MODE: level_nxt = mirror(level_r);
        OP_DOWN: begin
          if (running_r) level_nxt = step_down(level_r);
        end
        OP_UP: begin
          if (!running_r) begin
            running_nxt = 1'b1;
            timing_nxt  = 1'b0;
            lvl_tmp     = LVL_P1;
          end
          level_nxt = step_up(lvl_tmp);
        end
        OP_CLEAR: begin
          minutes_nxt = '0;
          seconds_nxt = '0;
          timing_nxt  = 1'b0;
        end
        OP_ADD: begin
          if (minutes_r <= pop_op.add_limit) begin
            minutes_nxt = minutes_r + pop_op.add_min;
            seconds_nxt = '0;
          end
          running_nxt = 1'b1;
          timing_nxt  = 1'b1;
        end
        OP_SET90: begin
          minutes_nxt = MIN_FULL;
          seconds_nxt = '0;
          running_nxt = 1'b1;
          timing_nxt  = 1'b1;
        end
        OP_TICK: begin
          if (presc_dec != 8'd0) begin
            presc_nxt = presc_dec;
          end else begin
            presc_nxt = tick_reload;
            if (timing_r) begin
              if (!running_r) begin
                minutes_nxt = '0;
                seconds_nxt = '0;
                timing_nxt  = 1'b0;
              end else if (seconds_r != '0) begin
                seconds_nxt = seconds_r - 6'd1;
              end else if (minutes_r == '0) begin
                running_nxt = 1'b0;
              end else begin
                seconds_nxt = SEC_WRAP;
                minutes_nxt = minutes_r - 7'd1;
              end
            end
          end
        end
        OP_SERIAL: begin
          level_nxt   = pop_op.level;
          running_nxt = (pop_op.level != LVL_IDLE);
          if (pop_op.min_ok)     minutes_nxt = pop_op.minutes;
          if (pop_op.sec_ok)     seconds_nxt = pop_op.seconds;
          if (pop_op.set_timing) timing_nxt  = 1'b1;
        end
        default: ;
      endcase

      // a stopped fan always shows idle and zero time
      if (!running_nxt) begin
        level_nxt   = LVL_IDLE;
        minutes_nxt = '0;
        seconds_nxt = '0;
      end
    end
  end

  // result word from the updated state
  assign min_dec = split_dec(minutes_nxt);
  assign sec_dec = split_dec({1'b0, seconds_nxt});

  always_comb begin
    res_nxt         = '0;
    res_nxt.level   = level_nxt;
    res_nxt.minutes = minutes_nxt;
    res_nxt.seconds = seconds_nxt;
    res_nxt.running = running_nxt;
    res_nxt.timing  = timing_nxt;
    res_nxt.seg_mt  = seg_of(min_dec[7:4]);
    res_nxt.seg_mo  = seg_of(min_dec[3:0]);
    res_nxt.seg_st  = seg_of(sec_dec[7:4]);
    res_nxt.seg_so  = seg_of(sec_dec[3:0]);
    if (!running_nxt) begin
      res_nxt.seg_sign  = seg_of(4'd0);
      res_nxt.seg_digit = seg_of(4'd0);
    end else begin
      case (level_nxt)
        LVL_M3:   begin res_nxt.seg_sign = SEG_MINUS;  res_nxt.seg_digit = seg_of(4'd3); end
        LVL_M2:   begin res_nxt.seg_sign = SEG_MINUS;  res_nxt.seg_digit = seg_of(4'd2); end
        LVL_M1:   begin res_nxt.seg_sign = SEG_MINUS;  res_nxt.seg_digit = seg_of(4'd1); end
        LVL_IDLE: begin res_nxt.seg_sign = seg_of(4'd0); res_nxt.seg_digit = seg_of(4'd0); end
        LVL_P1:   begin res_nxt.seg_sign = seg_of(4'd0); res_nxt.seg_digit = seg_of(4'd1); end
        LVL_P2:   begin res_nxt.seg_sign = seg_of(4'd0); res_nxt.seg_digit = seg_of(4'd2); end
        LVL_P3:   begin res_nxt.seg_sign = seg_of(4'd0); res_nxt.seg_digit = seg_of(4'd3); end
        default:  begin res_nxt.seg_sign = SEG_E;        res_nxt.seg_digit = SEG_E;        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      timing_r    <= 1'b0;
      level_r     <= LVL_IDLE;
      minutes_r   <= '0;
      seconds_r   <= '0;
      presc_r     <= TPS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      running_r <= running_nxt;
      timing_r  <= timing_nxt;
      level_r   <= level_nxt;
      minutes_r <= minutes_nxt;
      seconds_r <= seconds_nxt;
      presc_r   <= presc_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.drive_level     = res_r.level;
  assign out_bus.minutes_left    = res_r.minutes;
  assign out_bus.seconds_left    = res_r.seconds;
  assign out_bus.fan_running     = res_r.running;
  assign out_bus.timer_active    = res_r.timing;
  assign out_bus.seg_level_sign  = res_r.seg_sign;
  assign out_bus.seg_level_digit = res_r.seg_digit;
  assign out_bus.seg_min_tens    = res_r.seg_mt;
  assign out_bus.seg_min_ones    = res_r.seg_mo;
  assign out_bus.seg_sec_tens    = res_r.seg_st;
  assign out_bus.seg_sec_ones    = res_r.seg_so;

endmodule
`default_nettype wire

>>> dv/fan_speed_timer_controller_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fan_speed_timer_controller_test - self-checking bench for the fan controller
// Sends remote key, tick, serial set and no-op words under random valid and
// ready gaps. Each result word is checked against a cycle-free model of the
// controller kept in the bench. The tick reload is swept between phases.
// ----------------------------------------------------------------------------
module fan_speed_timer_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fstc_pkg::*;

  // cmd value 3 has no meaning in the block: state must hold
  localparam logic [1:0] CMD_NOP = 2'd3;

  // watchdog: cycles with no handshake on any channel before giving up
  localparam int QUIET_LIMIT  = 2000;
  // settle time after the last result
  localparam int DRAIN_CYCLES = 10;

  localparam logic [6:0] DIGIT_SEGS [10] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  localparam logic [7:0] KNOWN_KEYS [17] = '{
    KEY_POWER, KEY_MODE, KEY_DOWN_A, KEY_DOWN_B, KEY_UP_A, KEY_UP_B, KEY_CLEAR,
    KEY_ADD10, KEY_ADD20, KEY_ADD30, KEY_ADD40, KEY_ADD50, KEY_ADD60, KEY_ADD70,
    KEY_ADD80, KEY_SET90, 8'hFF
  };

  localparam logic [7:0] KNOWN_LEVELS [7] = '{
    LVL_M3, LVL_M2, LVL_M1, LVL_IDLE, LVL_P1, LVL_P2, LVL_P3
  };

  // one input word
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] key_code;
    logic [7:0] key_inverse;
    logic [7:0] level;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } fan_event_t;

  // one result word
  typedef struct packed {
    logic [7:0] drive_level;
    logic [6:0] minutes_left;
    logic [5:0] seconds_left;
    logic       fan_running;
    logic       timer_active;
    logic [6:0] seg_level_sign;
    logic [6:0] seg_level_digit;
    logic [6:0] seg_min_tens;
    logic [6:0] seg_min_ones;
    logic [6:0] seg_sec_tens;
    logic [6:0] seg_sec_ones;
  } fan_status_t;

  logic clk;
  logic rst_n;

  fstc_in_if  in_bus();
  fstc_out_if out_bus();
  fstc_cfg_if cfg_bus();

  fan_speed_timer_controller i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Controller state as the bench sees it
  // ---------------------------------------------------------------------------
  logic       fan_on;
  logic       countdown_on;
  logic [7:0] level_now;
  logic [6:0] mins_now;
  logic [5:0] secs_now;
  logic [7:0] prescale_now;
  logic [7:0] tick_reload;

  fan_event_t  pending_events[$];   // words not yet handed to the driver
  fan_status_t expected_status[$];  // predicted results, oldest first
  fan_event_t  word_on_bus;         // word currently offered on in_bus

  int words_in_flight = 0;  // queued plus on the bus, not yet accepted
  int idle_pct        = 30; // chance in a hundred that a side idles this cycle
  int error_count     = 0;
  int quiet_cycles    = 0;
  int key_words       = 0;
  int tick_words      = 0;
  int serial_words    = 0;
  int other_words     = 0;
  int results_checked = 0;
  int reload_writes   = 0;

  // Apply one accepted word to the tracked state and build the result word
  // the controller must return for it.
  function automatic fan_status_t next_fan_status(input fan_event_t ev);
    fan_status_t st;
    int          add_mins;
    case (ev.cmd)
      CMD_KEY: begin
        // a key only counts when the check byte is its exact inverse
        if (ev.key_inverse == 8'(~ev.key_code)) begin
          case (ev.key_code)
            KEY_POWER: begin
              if (!fan_on) begin
                fan_on    = 1'b1;
                level_now = LVL_P1;
              end else begin
                fan_on    = 1'b0;
                level_now = LVL_IDLE;
                mins_now  = '0;
                secs_now  = '0;
              end
              countdown_on = 1'b0;
            end
            KEY_MODE: begin
              // mirror about idle; odd levels stay put
              case (level_now)
                LVL_M3:  level_now = LVL_P3;
                LVL_M2:  level_now = LVL_P2;
                LVL_M1:  level_now = LVL_P1;
                LVL_P1:  level_now = LVL_M1;
                LVL_P2:  level_now = LVL_M2;
                LVL_P3:  level_now = LVL_M3;
                default: ;
              endcase
            end
            KEY_DOWN_A, KEY_DOWN_B: begin
              if (fan_on) begin
                case (level_now)
                  LVL_M3:  level_now = LVL_M2;
                  LVL_M2:  level_now = LVL_M1;
                  LVL_M1:  level_now = LVL_IDLE;
                  LVL_P1:  level_now = LVL_IDLE;
                  LVL_P2:  level_now = LVL_P1;
                  LVL_P3:  level_now = LVL_P2;
                  default: ;
                endcase
              end
            end
            KEY_UP_A, KEY_UP_B: begin
              // a stopped fan starts at +1 and then still takes the step
              if (!fan_on) begin
                fan_on       = 1'b1;
                level_now    = LVL_P1;
                countdown_on = 1'b0;
              end
              case (level_now)
                LVL_M2:   level_now = LVL_M3;
                LVL_M1:   level_now = LVL_M2;
                LVL_IDLE: level_now = LVL_P1;
                LVL_P1:   level_now = LVL_P2;
                LVL_P2:   level_now = LVL_P3;
                default:  ;
              endcase
            end
            KEY_CLEAR: begin
              mins_now     = '0;
              secs_now     = '0;
              countdown_on = 1'b0;
            end
            KEY_ADD10, KEY_ADD20, KEY_ADD30, KEY_ADD40,
            KEY_ADD50, KEY_ADD60, KEY_ADD70, KEY_ADD80: begin
              case (ev.key_code)
                KEY_ADD10: add_mins = 10;
                KEY_ADD20: add_mins = 20;
                KEY_ADD30: add_mins = 30;
                KEY_ADD40: add_mins = 40;
                KEY_ADD50: add_mins = 50;
                KEY_ADD60: add_mins = 60;
                KEY_ADD70: add_mins = 70;
                default:   add_mins = 80;
              endcase
              // the sum is capped at 90 minutes; flags are set regardless
              if (int'(mins_now) + add_mins <= 90) begin
                mins_now = 7'(int'(mins_now) + add_mins);
                secs_now = '0;
              end
              fan_on       = 1'b1;
              countdown_on = 1'b1;
            end
            KEY_SET90: begin
              mins_now     = MIN_FULL;
              secs_now     = '0;
              fan_on       = 1'b1;
              countdown_on = 1'b1;
            end
            default: ;
          endcase
        end
      end
      CMD_TICK: begin
        // 8-bit prescaler; a zero reload wraps to a 256-tick second
        prescale_now = prescale_now - 8'd1;
        if (prescale_now == 8'd0) begin
          prescale_now = tick_reload;
          if (countdown_on) begin
            if (!fan_on) begin
              // second after the countdown ran out: drop the timer
              mins_now     = '0;
              secs_now     = '0;
              countdown_on = 1'b0;
            end else if (secs_now != '0) begin
              secs_now = secs_now - 6'd1;
            end else if (mins_now == '0) begin
              fan_on = 1'b0;
            end else begin
              secs_now = SEC_WRAP;
              mins_now = mins_now - 7'd1;
            end
          end
        end
      end
      CMD_SERIAL: begin
        level_now = ev.level;
        fan_on    = (ev.level != LVL_IDLE);
        if (ev.minutes <= SER_MIN_MAX) mins_now = ev.minutes[6:0];
        if (ev.seconds <= SER_SEC_MAX) secs_now = ev.seconds[5:0];
        // raw bytes decide the timer flag, taken or not
        if (ev.minutes != 8'd0 || ev.seconds != 8'd0) countdown_on = 1'b1;
      end
      default: ;
    endcase

    // a stopped fan always shows idle level and zero time
    if (!fan_on) begin
      level_now = LVL_IDLE;
      mins_now  = '0;
      secs_now  = '0;
    end

    if (!fan_on) begin
      st.seg_level_sign  = DIGIT_SEGS[0];
      st.seg_level_digit = DIGIT_SEGS[0];
    end else begin
      case (level_now)
        LVL_M3:   begin st.seg_level_sign = SEG_MINUS;     st.seg_level_digit = DIGIT_SEGS[3]; end
        LVL_M2:   begin st.seg_level_sign = SEG_MINUS;     st.seg_level_digit = DIGIT_SEGS[2]; end
        LVL_M1:   begin st.seg_level_sign = SEG_MINUS;     st.seg_level_digit = DIGIT_SEGS[1]; end
        LVL_IDLE: begin st.seg_level_sign = DIGIT_SEGS[0]; st.seg_level_digit = DIGIT_SEGS[0]; end
        LVL_P1:   begin st.seg_level_sign = DIGIT_SEGS[0]; st.seg_level_digit = DIGIT_SEGS[1]; end
        LVL_P2:   begin st.seg_level_sign = DIGIT_SEGS[0]; st.seg_level_digit = DIGIT_SEGS[2]; end
        LVL_P3:   begin st.seg_level_sign = DIGIT_SEGS[0]; st.seg_level_digit = DIGIT_SEGS[3]; end
        default:  begin st.seg_level_sign = SEG_E;         st.seg_level_digit = SEG_E;         end
      endcase
    end

    st.drive_level  = level_now;
    st.minutes_left = mins_now;
    st.seconds_left = secs_now;
    st.fan_running  = fan_on;
    st.timer_active = countdown_on;
    st.seg_min_tens = DIGIT_SEGS[(int'(mins_now) / 10) % 10];
    st.seg_min_ones = DIGIT_SEGS[int'(mins_now) % 10];
    st.seg_sec_tens = DIGIT_SEGS[(int'(secs_now) / 10) % 10];
    st.seg_sec_ones = DIGIT_SEGS[int'(secs_now) % 10];
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders; fields the command ignores carry random junk
  // ---------------------------------------------------------------------------
  function automatic fan_event_t junk_word(input logic [1:0] cmd);
    fan_event_t ev;
    ev.cmd         = cmd;
    ev.key_code    = 8'($urandom);
    ev.key_inverse = 8'($urandom);
    ev.level       = 8'($urandom);
    ev.minutes     = 8'($urandom);
    ev.seconds     = 8'($urandom);
    return ev;
  endfunction

  function automatic fan_event_t key_word(input logic [7:0] code);
    fan_event_t ev;
    ev             = junk_word(CMD_KEY);
    ev.key_code    = code;
    ev.key_inverse = ~code;
    return ev;
  endfunction

  function automatic fan_event_t serial_word(input logic [7:0] lvl,
                                             input logic [7:0] mins,
                                             input logic [7:0] secs);
    fan_event_t ev;
    ev         = junk_word(CMD_SERIAL);
    ev.level   = lvl;
    ev.minutes = mins;
    ev.seconds = secs;
    return ev;
  endfunction

  // Mostly well-formed keys, ticks and short serial times so the countdown really
  // runs out; the rest is broken check bytes, unknown codes and no-ops.
  function automatic fan_event_t random_word();
    fan_event_t ev;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      ev = key_word($urandom_range(3) != 0 ? KNOWN_KEYS[$urandom_range(16)]
                                           : 8'($urandom));
      if ($urandom_range(9) == 0) ev.key_inverse = 8'($urandom);
    end else if (pick < 80) begin
      ev = junk_word(CMD_TICK);
    end else if (pick < 96) begin
      ev = serial_word($urandom_range(9) < 7 ? KNOWN_LEVELS[$urandom_range(6)]
                                             : 8'($urandom),
                       $urandom_range(1) ? 8'($urandom_range(3))
                                         : 8'($urandom_range(255)),
                       $urandom_range(4) != 0 ? 8'($urandom_range(59))
                                              : 8'($urandom_range(255)));
      if ($urandom_range(9) == 0) begin
        ev.minutes = 8'd0;
        ev.seconds = 8'd0;
      end
    end else begin
      ev = junk_word(CMD_NOP);
    end
    return ev;
  endfunction

  task automatic send_word(input fan_event_t ev);
    pending_events.push_back(ev);
    words_in_flight++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_word(random_word());
  endtask

  // hold the sender until every sent word has its result back
  task automatic wait_until_drained();
    do @(posedge clk);
    while (words_in_flight != 0 || expected_status.size() != 0);
  endtask

  // reload write; only called with the block idle
  task automatic set_tick_reload(input logic [7:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    tick_reload = value;
    reload_writes++;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued word, keeps it until it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        // predict at the accepting edge, in acceptance order
        expected_status.push_back(next_fan_status(word_on_bus));
        words_in_flight--;
        case (word_on_bus.cmd)
          CMD_KEY:    key_words++;
          CMD_TICK:   tick_words++;
          CMD_SERIAL: serial_words++;
          default:    other_words++;
        endcase
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct) begin
          word_on_bus            = pending_events.pop_front();
          in_bus.valid          <= 1'b1;
          in_bus.cmd            <= word_on_bus.cmd;
          in_bus.key_code       <= word_on_bus.key_code;
          in_bus.key_inverse    <= word_on_bus.key_inverse;
          in_bus.serial_level   <= word_on_bus.level;
          in_bus.serial_minutes <= word_on_bus.minutes;
          in_bus.serial_seconds <= word_on_bus.seconds;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random ready, every taken result word checked in order
  // ---------------------------------------------------------------------------
  fan_status_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_status.size() == 0) begin
          $error("result word with no word pending: level 0x%0h time %0d:%0d",
                 out_bus.drive_level, out_bus.minutes_left, out_bus.seconds_left);
          error_count++;
        end else begin
          want = expected_status.pop_front();
          results_checked++;
          check_field("drive_level",     want.drive_level,     out_bus.drive_level);
          check_field("minutes_left",    want.minutes_left,    out_bus.minutes_left);
          check_field("seconds_left",    want.seconds_left,    out_bus.seconds_left);
          check_field("fan_running",     want.fan_running,     out_bus.fan_running);
          check_field("timer_active",    want.timer_active,    out_bus.timer_active);
          check_field("seg_level_sign",  want.seg_level_sign,  out_bus.seg_level_sign);
          check_field("seg_level_digit", want.seg_level_digit, out_bus.seg_level_digit);
          check_field("seg_min_tens",    want.seg_min_tens,    out_bus.seg_min_tens);
          check_field("seg_min_ones",    want.seg_min_ones,    out_bus.seg_min_ones);
          check_field("seg_sec_tens",    want.seg_sec_tens,    out_bus.seg_sec_tens);
          check_field("seg_sec_ones",    want.seg_sec_ones,    out_bus.seg_sec_ones);
        end
      end
      out_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a stuck handshake on every channel ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no handshake for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    fan_event_t ev;

    // every block input known from time zero
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.cmd            = CMD_KEY;
    in_bus.key_code       = 8'h00;
    in_bus.key_inverse    = 8'h00;
    in_bus.serial_level   = 8'h00;
    in_bus.serial_minutes = 8'h00;
    in_bus.serial_seconds = 8'h00;
    out_bus.ready         = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.data          = 8'h00;

    // reset values of the tracked state
    fan_on       = 1'b0;
    countdown_on = 1'b0;
    level_now    = LVL_IDLE;
    mins_now     = '0;
    secs_now     = '0;
    prescale_now = TPS_RESET;
    tick_reload  = TPS_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: keys and serial sets at the reset reload ---------------
    ev = junk_word(CMD_NOP);              // unused command, all ones
    ev.key_code = 8'hFF; ev.key_inverse = 8'hFF; ev.level = 8'hFF;
    ev.minutes = 8'hFF; ev.seconds = 8'hFF;
    send_word(ev);
    ev = key_word(KEY_POWER);             // check byte wrong: ignored
    ev.key_inverse = KEY_POWER;
    send_word(ev);
    send_word(key_word(8'hFF));           // unknown codes at both extremes
    send_word(key_word(8'h00));
    send_word(key_word(KEY_MODE));        // stopped: nothing to mirror
    send_word(key_word(KEY_DOWN_A));      // stopped: down does nothing
    send_word(key_word(KEY_UP_A));        // start at +1, then step to +2
    send_word(key_word(KEY_UP_B));        // +3
    send_word(key_word(KEY_UP_A));        // already at top
    send_word(key_word(KEY_MODE));        // -3
    send_word(key_word(KEY_UP_B));        // -3 has no up step
    send_word(key_word(KEY_DOWN_B));      // -2
    send_word(key_word(KEY_DOWN_A));      // -1
    send_word(key_word(KEY_DOWN_B));      // idle level, still running
    send_word(key_word(KEY_DOWN_A));      // no step below idle
    send_word(key_word(KEY_UP_A));        // +1
    send_word(key_word(KEY_MODE));        // -1
    send_word(key_word(KEY_POWER));       // off
    send_word(key_word(KEY_ADD10));       // digit key starts a stopped fan
    send_word(key_word(KEY_ADD80));       // exactly 90
    send_word(key_word(KEY_ADD20));       // over the cap: time kept
    send_word(key_word(KEY_CLEAR));
    send_word(key_word(KEY_SET90));
    send_word(serial_word(8'h55, 8'hFF, 8'hFF)); // odd level, bytes rejected
    send_word(key_word(KEY_MODE));        // odd level stays in all three
    send_word(key_word(KEY_UP_B));
    send_word(key_word(KEY_DOWN_B));
    send_word(serial_word(LVL_IDLE, 8'd0, 8'd0));
    send_word(serial_word(LVL_M3, 8'd99, 8'd59));
    send_word(junk_word(CMD_TICK));
    send_word(serial_word(LVL_P3, 8'd100, 8'd60)); // just past both limits
    wait_until_drained();

    // --- one tick per second: run a short countdown out ---------------------
    // The new reload applies at the next rollover, so enough ticks are sent
    // to cover the old prescaler count, the last second and the timer drop.
    set_tick_reload(8'd1);
    send_word(serial_word(LVL_P1, 8'd0, 8'd2));
    repeat (25) send_word(junk_word(CMD_TICK));
    send_random(30);
    wait_until_drained();

    // --- three ticks per second, both sides busy every cycle -----------------
    set_tick_reload(8'd3);
    idle_pct = 0;
    send_random(50);
    wait_until_drained();
    idle_pct = 30;

    // --- two ticks per second; leaves at most two ticks in the prescaler -----
    set_tick_reload(8'd2);
    send_random(40);
    wait_until_drained();

    // --- zero reload: prescaler wraps, a second is 256 ticks -----------------
    // The last second ends within two ticks; the stop comes one full
    // 256-tick second later.
    set_tick_reload(8'd0);
    send_word(serial_word(LVL_P2, 8'd0, 8'd1));
    repeat (260) send_word(junk_word(CMD_TICK));
    wait_until_drained();

    // --- slowest configured second ------------------------------------------
    set_tick_reload(8'd255);
    send_random(20);
    wait_until_drained();

    // let any stray result word show up before closing
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d keys, %0d ticks, %0d serial sets, %0d no-ops",
             key_words + tick_words + serial_words + other_words,
             key_words, tick_words, serial_words, other_words);
    $display("Checked %0d result words over %0d tick reload settings",
             results_checked, reload_writes + 1);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
